/* src/etbc_pkg.sv */
// Shared types, widths and operation codes for the event time bin compressor.
`default_nettype none

package etbc_pkg;

   // Parameter defaults handed to the top level.
   localparam int MAX_EDGES_DEF  = 2048;
   localparam int TOF_BITS_DEF   = 32;
   localparam int COUNT_BITS_DEF = 24;

   // Fixed widths of the channels and of the bin sums.
   localparam int SUM_BITS       = 56;
   localparam int CFG_W          = 12;
   localparam int OP_W           = 2;
   localparam int EIDX_W         = 11;
   localparam int VALUE_W        = 32;
   localparam int MEAN_W         = 32;
   localparam int WEIGHT_W       = 24;

   localparam logic [CFG_W-1:0] EDGE_COUNT_RST = CFG_W'(2);

   // Operation codes of an input item.
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
   localparam logic [OP_W-1:0] OP_DRAIN = 2'd2;
   localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [EIDX_W-1:0]  edge_index;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                has_event;
      logic [MEAN_W-1:0]   mean_tof;
      logic [WEIGHT_W-1:0] weight;
      logic                last;
      logic                rejected;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic clear_step;
      logic edge_write;
      logic add_reject;
      logic escan_start;
      logic escan_step;
      logic ehi_read;
      logic bin_read;
      logic bin_update;
      logic drain_empty;
      logic dscan_start;
      logic dscan_step;
      logic drain_hit;
      logic div_step;
      logic load_rsp;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            clear_done;
      logic            no_bins;
      logic            occ_zero;
      logic            escan_done;
      logic            found;
      logic            ehi_reject;
      logic            bin_full;
      logic            dchk_hit;
      logic            div_last;
      logic            out_free;
   } sts_type;

endpackage

`default_nettype wire

/* src/etbc_ram.sv */
// Generic single write port RAM with one registered read port.
`default_nettype none

module etbc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* src/etbc_ctrl.sv */
// Controller state machine that sequences each item through the datapath.
`default_nettype none

module etbc_ctrl
   import etbc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_DISPATCH = 4'd2;
   localparam logic [3:0] S_ESCAN    = 4'd3;
   localparam logic [3:0] S_EHI_RD   = 4'd4;
   localparam logic [3:0] S_EHI_CHK  = 4'd5;
   localparam logic [3:0] S_BIN_CHK  = 4'd6;
   localparam logic [3:0] S_DSCAN    = 4'd7;
   localparam logic [3:0] S_DIV      = 4'd8;
   localparam logic [3:0] S_FINISH   = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_stall = (state_ff != S_IDLE);

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (sts.op)
               OP_LOAD: begin
                  cmd.edge_write = 1'b1;
                  state_in       = S_FINISH;
               end
               OP_ADD: begin
                  if (sts.no_bins) begin
                     cmd.add_reject = 1'b1;
                     state_in       = S_FINISH;
                  end else begin
                     cmd.escan_start = 1'b1;
                     state_in        = S_ESCAN;
                  end
               end
               OP_DRAIN: begin
                  if (sts.occ_zero) begin
                     cmd.drain_empty = 1'b1;
                     state_in        = S_FINISH;
                  end else begin
                     cmd.dscan_start = 1'b1;
                     state_in        = S_DSCAN;
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_ESCAN: begin
            if (sts.escan_done) begin
               if (sts.found) begin
                  state_in = S_EHI_RD;
               end else begin
                  cmd.add_reject = 1'b1;
                  state_in       = S_FINISH;
               end
            end else begin
               cmd.escan_step = 1'b1;
            end
         end
         S_EHI_RD: begin
            cmd.ehi_read = 1'b1;
            state_in     = S_EHI_CHK;
         end
         S_EHI_CHK: begin
            if (sts.ehi_reject) begin
               cmd.add_reject = 1'b1;
               state_in       = S_FINISH;
            end else begin
               cmd.bin_read = 1'b1;
               state_in     = S_BIN_CHK;
            end
         end
         S_BIN_CHK: begin
            if (sts.bin_full) begin
               cmd.add_reject = 1'b1;
            end else begin
               cmd.bin_update = 1'b1;
            end
            state_in = S_FINISH;
         end
         S_DSCAN: begin
            if (sts.dchk_hit) begin
               cmd.drain_hit = 1'b1;
               state_in      = S_DIV;
            end else begin
               cmd.dscan_step = 1'b1;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // A result is only loaded at the end of an item.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> state_ff == S_FINISH)
      else $error("result loaded outside the finish state");

   // A new item is never taken while the bin clearing pass runs.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !cmd.accept)
      else $error("item accepted during clearing pass");

   // The drain scan is only entered with at least one occupied bin.
   assert property (@(posedge clock) disable iff (reset)
      cmd.dscan_start |-> !sts.occ_zero)
      else $error("drain scan started with no occupied bin");

endmodule

`default_nettype wire

/* src/etbc_datapath.sv */
// Datapath: edge and bin memories, scan pointers, serial divider and result registers.
`default_nettype none

module etbc_datapath
   import etbc_pkg::*;
#(
   parameter int MAX_EDGES  = MAX_EDGES_DEF,
   parameter int TOF_BITS   = TOF_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire req_type          req_data,
   input  wire logic             csr_wr_en,
   input  wire logic [CFG_W-1:0] csr_wr_data,
   input  wire cmd_type          cmd,
   output sts_type               sts,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_data
);

   localparam int IDX_W     = $clog2(MAX_EDGES);
   localparam int E_W       = IDX_W + 1;
   localparam int BIN_TOTAL = MAX_EDGES - 1;
   localparam int BIN_W     = COUNT_BITS + SUM_BITS;
   localparam int DCNT_W    = $clog2(SUM_BITS);

   // Captured item.
   logic [OP_W-1:0]       op_ff, op_in;
   logic [EIDX_W-1:0]     idx_ff, idx_in;
   logic [TOF_BITS-1:0]   tof_ff, tof_in;

   logic [CFG_W-1:0]      edge_count_ff, edge_count_in;

   // Scan and bin bookkeeping.
   logic [IDX_W-1:0]      scan_ff, scan_in;
   logic                  chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]      chk_addr_ff, chk_addr_in;
   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      bin_ff, bin_in;
   logic [IDX_W-1:0]      occ_ff, occ_in;
   logic [IDX_W-1:0]      drain_pos_ff, drain_pos_in;

   // Pending result.
   logic                  res_has_ff, res_has_in;
   logic [COUNT_BITS-1:0] res_weight_ff, res_weight_in;
   logic                  res_last_ff, res_last_in;
   logic                  res_rej_ff, res_rej_in;

   // Serial divider.
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [SUM_BITS-1:0]   q_ff, q_in;
   logic [COUNT_BITS-1:0] div_ff, div_in;
   logic [DCNT_W-1:0]     dcnt_ff, dcnt_in;

   // Output register.
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   // Memory ports.
   logic                  edge_we;
   logic [IDX_W-1:0]      edge_raddr;
   logic [TOF_BITS-1:0]   edge_rd;
   logic                  bin_we;
   logic [IDX_W-1:0]      bin_waddr;
   logic [BIN_W-1:0]      bin_wdata;
   logic [IDX_W-1:0]      bin_raddr;
   logic [BIN_W-1:0]      bin_rd;
   logic [COUNT_BITS-1:0] bin_rd_cnt;
   logic [SUM_BITS-1:0]   bin_rd_sum;

   logic [E_W-1:0]        e_use;
   logic                  issue;
   logic                  idx_ok;
   logic [IDX_W-1:0]      scan_wrap;
   logic [IDX_W-1:0]      dstart;
   logic [COUNT_BITS:0]   rem_sh;
   logic                  div_ge;

   assign bin_rd_cnt = bin_rd[BIN_W-1 -: COUNT_BITS];
   assign bin_rd_sum = bin_rd[SUM_BITS-1:0];

   // Edges in use, saturated to the table depth.
   always_comb begin
      if (32'(edge_count_ff) > 32'(MAX_EDGES)) begin
         e_use = E_W'(MAX_EDGES);
      end else begin
         e_use = E_W'(edge_count_ff);
      end
   end

   assign issue     = (E_W'(scan_ff) + E_W'(1)) < e_use;
   assign idx_ok    = 32'(idx_ff) < 32'(MAX_EDGES);
   assign scan_wrap = (32'(scan_ff) >= 32'(BIN_TOTAL - 1)) ? '0 : scan_ff + IDX_W'(1);
   assign dstart    = (32'(drain_pos_ff) >= 32'(BIN_TOTAL)) ? '0 : drain_pos_ff;

   // One restoring divide step.
   assign rem_sh = {rem_ff, q_ff[SUM_BITS-1]};
   assign div_ge = rem_sh >= {1'b0, div_ff};

   assign edge_we    = cmd.edge_write && idx_ok;
   assign edge_raddr = cmd.ehi_read ? bin_ff + IDX_W'(1) : scan_ff;
   assign bin_raddr  = cmd.bin_read ? bin_ff : scan_ff;

   // Next state of the datapath registers.
   always_comb begin
      op_in         = op_ff;
      idx_in        = idx_ff;
      tof_in        = tof_ff;
      edge_count_in = csr_wr_en ? csr_wr_data : edge_count_ff;
      scan_in       = scan_ff;
      chk_valid_in  = chk_valid_ff;
      chk_addr_in   = chk_addr_ff;
      found_in      = found_ff;
      bin_in        = bin_ff;
      occ_in        = occ_ff;
      drain_pos_in  = drain_pos_ff;
      res_has_in    = res_has_ff;
      res_weight_in = res_weight_ff;
      res_last_in   = res_last_ff;
      res_rej_in    = res_rej_ff;
      rem_in        = rem_ff;
      q_in          = q_ff;
      div_in        = div_ff;
      dcnt_in       = dcnt_ff;
      bin_we        = 1'b0;
      bin_waddr     = scan_ff;
      bin_wdata     = '0;

      if (cmd.accept) begin
         op_in         = req_data.op;
         idx_in        = req_data.edge_index;
         tof_in        = TOF_BITS'(req_data.value);
         res_has_in    = 1'b0;
         res_weight_in = '0;
         res_last_in   = 1'b0;
         res_rej_in    = 1'b0;
      end

      // Clearing pass over the bin memory.
      if (cmd.clear_step) begin
         bin_we  = 1'b1;
         scan_in = scan_ff + IDX_W'(1);
      end

      if (cmd.add_reject) begin
         res_rej_in = 1'b1;
      end

      // Edge scan: keep the highest edge not above the event time.
      if (cmd.escan_start) begin
         scan_in      = '0;
         chk_valid_in = 1'b0;
         found_in     = 1'b0;
      end
      if (cmd.escan_step) begin
         chk_valid_in = issue;
         chk_addr_in  = scan_ff;
         if (issue) begin
            scan_in = scan_ff + IDX_W'(1);
         end
         if (chk_valid_ff && (edge_rd <= tof_ff)) begin
            found_in = 1'b1;
            bin_in   = chk_addr_ff;
         end
      end

      // Add the event into its bin.
      if (cmd.bin_update) begin
         bin_we    = 1'b1;
         bin_waddr = bin_ff;
         bin_wdata = {bin_rd_cnt + COUNT_BITS'(1), bin_rd_sum + SUM_BITS'(tof_ff)};
         if (bin_rd_cnt == '0) begin
            occ_in = occ_ff + IDX_W'(1);
         end
      end

      if (cmd.drain_empty) begin
         res_last_in  = 1'b1;
         drain_pos_in = '0;
      end

      // Drain scan: wrap round the bins until an occupied one shows up.
      if (cmd.dscan_start) begin
         scan_in      = dstart;
         chk_valid_in = 1'b0;
      end
      if (cmd.dscan_step) begin
         scan_in      = scan_wrap;
         chk_valid_in = 1'b1;
         chk_addr_in  = scan_ff;
      end
      if (cmd.drain_hit) begin
         bin_we        = 1'b1;
         bin_waddr     = chk_addr_ff;
         occ_in        = occ_ff - IDX_W'(1);
         res_has_in    = 1'b1;
         res_weight_in = bin_rd_cnt;
         res_last_in   = (occ_ff == IDX_W'(1));
         drain_pos_in  = (occ_ff == IDX_W'(1)) ? '0 : chk_addr_ff + IDX_W'(1);
         rem_in        = '0;
         q_in          = bin_rd_sum;
         div_in        = bin_rd_cnt;
         dcnt_in       = '0;
      end

      if (cmd.div_step) begin
         rem_in  = div_ge ? COUNT_BITS'(rem_sh - {1'b0, div_ff}) : COUNT_BITS'(rem_sh);
         q_in    = {q_ff[SUM_BITS-2:0], div_ge};
         dcnt_in = dcnt_ff + DCNT_W'(1);
      end
   end

   // Output register next state.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in     = 1'b1;
         rsp_in.has_event = res_has_ff;
         rsp_in.mean_tof  = res_has_ff ? MEAN_W'(q_ff) : '0;
         rsp_in.weight    = WEIGHT_W'(res_weight_ff);
         rsp_in.last      = res_last_ff;
         rsp_in.rejected  = res_rej_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         edge_count_ff <= EDGE_COUNT_RST;
         scan_ff       <= '0;
         chk_valid_ff  <= 1'b0;
         occ_ff        <= '0;
         drain_pos_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         edge_count_ff <= edge_count_in;
         scan_ff       <= scan_in;
         chk_valid_ff  <= chk_valid_in;
         occ_ff        <= occ_in;
         drain_pos_ff  <= drain_pos_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      tof_ff        <= tof_in;
      chk_addr_ff   <= chk_addr_in;
      found_ff      <= found_in;
      bin_ff        <= bin_in;
      res_has_ff    <= res_has_in;
      res_weight_ff <= res_weight_in;
      res_last_ff   <= res_last_in;
      res_rej_ff    <= res_rej_in;
      rem_ff        <= rem_in;
      q_ff          <= q_in;
      div_ff        <= div_in;
      dcnt_ff       <= dcnt_in;
      rsp_ff        <= rsp_in;
   end

   etbc_ram #(
      .WIDTH (TOF_BITS),
      .DEPTH (MAX_EDGES)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_we),
      .wr_addr (IDX_W'(idx_ff)),
      .wr_data (tof_ff),
      .rd_addr (edge_raddr),
      .rd_data (edge_rd)
   );

   etbc_ram #(
      .WIDTH (BIN_W),
      .DEPTH (MAX_EDGES)
   ) u_bin_ram (
      .clock   (clock),
      .wr_en   (bin_we),
      .wr_addr (bin_waddr),
      .wr_data (bin_wdata),
      .rd_addr (bin_raddr),
      .rd_data (bin_rd)
   );

   // Status to the controller.
   always_comb begin
      sts.op         = op_ff;
      sts.clear_done = (32'(scan_ff) == 32'(MAX_EDGES - 1));
      sts.no_bins    = (e_use < E_W'(2));
      sts.occ_zero   = (occ_ff == '0);
      sts.escan_done = !issue && !chk_valid_ff;
      sts.found      = found_ff;
      sts.ehi_reject = (tof_ff >= edge_rd);
      sts.bin_full   = &bin_rd_cnt;
      sts.dchk_hit   = chk_valid_ff && (bin_rd_cnt != '0);
      sts.div_last   = (dcnt_ff == DCNT_W'(SUM_BITS - 1));
      sts.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The occupied bin count never exceeds the number of bins.
   assert property (@(posedge clock) disable iff (reset)
      32'(occ_ff) <= 32'(BIN_TOTAL))
      else $error("occupied bin count out of range");

   // A drained bin always comes with a nonzero occupied count.
   assert property (@(posedge clock) disable iff (reset)
      cmd.drain_hit |-> occ_ff != '0)
      else $error("drain hit with no occupied bin");

   // A waiting result is never overwritten.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten while stalled");

endmodule

`default_nettype wire

/* src/event_time_bin_compressor.sv */
// Event time bin compressor: bins time-of-flight events and drains per-bin means.
//
// Usage: the request channel (req_valid, req_stall, req_data) carries one item
// with an op: load edge writes one bin edge, add event places a time of flight
// into its bin, and drain returns the next occupied bin as mean time and weight.
// Every item gives exactly one result item on the rsp channel (rsp_valid,
// rsp_stall, rsp_data). The csr port writes the number of edges in use.
// Items are worked one at a time. An add scans the edges in use in the edge
// memory one entry a cycle through its single read port. A drain scans the bin
// memory to the next occupied bin (one bin-memory read a cycle), then divides
// the 56-bit sum by the count one bit a cycle. After reset the block clears the
// bin memory and holds req_stall high meanwhile; csr writes are taken at any
// time. A finished result waits in the output register while the next item is
// accepted and worked on; that item's result waits for the register to free up
// while rsp_stall is high.
`default_nettype none

module event_time_bin_compressor
   import etbc_pkg::*;
#(
   parameter int MAX_EDGES  = MAX_EDGES_DEF,
   parameter int TOF_BITS   = TOF_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_data,
   input  wire logic             csr_wr_en,
   input  wire logic [CFG_W-1:0] csr_wr_data
);

   cmd_type cmd;
   sts_type sts;

   etbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   etbc_datapath #(
      .MAX_EDGES  (MAX_EDGES),
      .TOF_BITS   (TOF_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire
